@@ sv/mt19937_keyed_byte_decrypt_top_defines.svh @@
// Assertion macros shared by the keyed byte decryptor RTL.
// Needs signals named clock and reset in the including module.
`ifndef MT19937_KEYED_BYTE_DECRYPT_TOP_DEFINES_SVH
`define MT19937_KEYED_BYTE_DECRYPT_TOP_DEFINES_SVH

// checked only outside reset
`define MTKD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define MTKD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/mtkd_pkg.sv @@
// Shared types, constants and twister functions for the keyed byte decryptor.
// No dependencies.
`default_nettype none
package mtkd_pkg;

   localparam int unsigned MT_N   = 624;
   localparam int unsigned MT_M   = 397;
   localparam int unsigned IDX_W  = 10;

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type     IDX_LAST     = idx_type'(MT_N - 1);
   localparam idx_type     IDX_WRAP     = idx_type'(MT_N - MT_M);
   localparam idx_type     IDX_FAR      = idx_type'(MT_M);
   localparam logic [31:0] MT_MATRIX    = 32'h9908_B0DF;
   localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
   localparam logic [31:0] MT_LOWER     = 32'h7FFF_FFFF;
   localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;

   localparam logic [31:0] SEED_RESET  = 32'h0000_0000;
   localparam logic [7:0]  KEY_A_RESET = 8'hC5;
   localparam logic [7:0]  KEY_B_RESET = 8'h83;
   localparam logic [7:0]  DELTA_RESET = 8'h53;

   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_DATA    = 1'b1;

   typedef enum logic [1:0] {
      CSR_SEED,
      CSR_KEY_A,
      CSR_KEY_B,
      CSR_DELTA
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_SEED_START,
      ST_SEED,
      ST_IDLE,
      ST_MIX
   } state_type;

   typedef struct packed {
      logic seed_start;
      logic seed_step;
      logic restart;
      logic fetch;
      logic mix;
   } ctl_cmd_type;

   typedef struct packed {
      logic seed_done;
      logic out_stall;
   } ctl_sts_type;

   function automatic logic [31:0] mt_mix(input logic [31:0] hi, input logic [31:0] lo,
                                         input logic [31:0] far);
      logic [31:0] y;
      y = (hi & MT_UPPER) | (lo & MT_LOWER);
      return far ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'h0);
   endfunction

   function automatic logic [31:0] mt_temper(input logic [31:0] w);
      logic [31:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage
`default_nettype wire

@@ sv/mtkd_channels.sv @@
// Word channel interfaces: request (kind, data_in) and response (data_out).
// No dependencies.
`default_nettype none
interface mtkd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_in;
   modport source (output valid, output kind, output data_in, input ready);
   modport sink   (input valid, input kind, input data_in, output ready);
endinterface

interface mtkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface
`default_nettype wire

@@ sv/mt19937_keyed_byte_decrypt_top.sv @@
// Top level of the MT19937 keyed byte decryptor.
// Depends on mtkd_pkg, mtkd_channels, mtkd_ctrl and mtkd_datapath.
//
// channel   direction  word contents
// req_ch    in         kind (0 restart, 1 data byte), data_in
// rsp_ch    out        data_out, one per data byte
// csr_*     in         write enable, index, 32-bit data
//
// A data byte takes one twister store read (two ports), then one mix/write.
// Seeding writes one word a cycle, all 624 words, after reset or after a restart.
// No request is taken during seeding; a stalled response holds the mix step.
`default_nettype none
module mt19937_keyed_byte_decrypt_top import mtkd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   mtkd_req_if.sink           req_ch,
   mtkd_rsp_if.source         rsp_ch,
   input  wire logic          csr_we,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_wdata
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   mtkd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mtkd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .data_in   (req_ch.data_in),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_ch.data_out)
   );

endmodule
`default_nettype wire

@@ sv/mtkd_ctrl.sv @@
// Sequencer for seeding, restart and per-byte twister steps.
// Depends on mtkd_pkg.
`default_nettype none
module mtkd_ctrl import mtkd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_kind,
   output logic             req_ready,
   input  wire ctl_sts_type sts,
   output ctl_cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEED_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SEED_START: state_in = ST_SEED;
         ST_SEED: begin
            if (sts.seed_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = (req_kind == KIND_DATA) ? ST_MIX : ST_SEED_START;
         end
         ST_MIX: begin
            if (!sts.out_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_SEED_START;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_SEED_START: cmd.seed_start = 1'b1;
         ST_SEED:       cmd.seed_step  = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.fetch   = req_valid && (req_kind == KIND_DATA);
            cmd.restart = req_valid && (req_kind == KIND_RESTART);
         end
         ST_MIX:        cmd.mix = !sts.out_stall;
         default:       cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ sv/mtkd_datapath.sv @@
// Twister word store, seeding recurrence, running keys, registers and output word.
// Depends on mtkd_pkg and the assertion macro header.
`default_nettype none
`include "mt19937_keyed_byte_decrypt_top_defines.svh"
module mtkd_datapath import mtkd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctl_cmd_type   cmd,
   output ctl_sts_type        sts,
   input  wire logic          csr_we,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_wdata,
   input  wire logic [7:0]    data_in,
   input  wire logic          rsp_ready,
   output logic               rsp_valid,
   output logic [7:0]         rsp_data
);

   logic [31:0] mem [MT_N];

   logic [31:0] seed_ff;
   logic [7:0]  key_a_start_ff, key_b_start_ff, delta_ff;
   logic [31:0] p_ff, cur_ff, rd1_ff, rd2_ff;
   idx_type     cnt_ff, idx_ff;
   logic [7:0]  key_a_ff, key_b_ff, data_ff, rsp_data_ff;
   logic        rsp_valid_ff;

   logic [31:0] seed_prod, seed_word, mixed, tempered, wdata;
   idx_type     ra1, ra2, waddr;
   logic        we;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff        <= SEED_RESET;
         key_a_start_ff <= KEY_A_RESET;
         key_b_start_ff <= KEY_B_RESET;
         delta_ff       <= DELTA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEED:  seed_ff        <= csr_wdata;
            CSR_KEY_A: key_a_start_ff <= csr_wdata[7:0];
            CSR_KEY_B: key_b_start_ff <= csr_wdata[7:0];
            CSR_DELTA: delta_ff       <= csr_wdata[7:0];
            default:   seed_ff        <= seed_ff;
         endcase
      end
   end

   // seeding step: one multiply per word
   assign seed_prod = MT_INIT_MULT * (p_ff ^ (p_ff >> 30));
   assign seed_word = seed_prod + {{(32-IDX_W){1'b0}}, cnt_ff};

   // words past the current index are old, words before it already twisted
   assign ra1      = (idx_ff == IDX_LAST) ? '0 : idx_ff + idx_type'(1);
   assign ra2      = (idx_ff < IDX_WRAP) ? idx_ff + IDX_FAR : idx_ff - IDX_WRAP;
   assign mixed    = mt_mix(cur_ff, rd1_ff, rd2_ff);
   assign tempered = mt_temper(mixed);

   always_comb begin
      we    = cmd.seed_start | cmd.seed_step | cmd.mix;
      waddr = idx_ff;
      wdata = mixed;
      if (cmd.seed_start) begin
         waddr = '0;
         wdata = seed_ff;
      end else if (cmd.seed_step) begin
         waddr = cnt_ff;
         wdata = seed_word;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.fetch) begin
         rd1_ff <= mem[ra1];
         rd2_ff <= mem[ra2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         idx_ff       <= '0;
         key_a_ff     <= '0;
         key_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.seed_start) begin
            cnt_ff <= idx_type'(1);
            idx_ff <= '0;
         end else if (cmd.seed_step) begin
            cnt_ff <= cnt_ff + idx_type'(1);
         end
         if (cmd.restart) begin
            key_a_ff <= key_a_start_ff;
            key_b_ff <= key_b_start_ff;
         end
         if (cmd.mix) begin
            idx_ff       <= (idx_ff == IDX_LAST) ? '0 : idx_ff + idx_type'(1);
            key_a_ff     <= key_a_ff + key_b_ff;
            key_b_ff     <= key_b_ff + delta_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_start) begin
         p_ff   <= seed_ff;
         cur_ff <= seed_ff;
      end else if (cmd.seed_step) begin
         p_ff <= seed_word;
      end else if (cmd.mix) begin
         cur_ff <= rd1_ff;
      end
      if (cmd.fetch) data_ff <= data_in;
      if (cmd.mix) rsp_data_ff <= data_ff ^ tempered[7:0] ^ key_a_ff;
   end

   assign sts.seed_done = (cnt_ff == IDX_LAST);
   assign sts.out_stall = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   `MTKD_ASSERT(a_idx_range, idx_ff <= IDX_LAST, "twister index past last word")
   `MTKD_ASSERT(a_mix_free, cmd.mix |-> !sts.out_stall, "step while output word stalled")
   `MTKD_ASSERT(a_mix_out, cmd.mix |=> rsp_valid_ff, "step gave no output word")
   `MTKD_ASSERT_ALWAYS(a_reset_out, reset |=> !rsp_valid_ff, "output word valid after reset")

endmodule
`default_nettype wire

@@ sim/tb_mt19937_keyed_byte_decrypt_top.sv @@
// Self-checking testbench for the MT19937 keyed byte decryptor.
// Holds its own twister and running-key predictor; depends on mtkd_pkg, mtkd_channels and the decryptor top.
`default_nettype none
module tb_mt19937_keyed_byte_decrypt_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mtkd_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_SEED;
   logic [31:0]   csr_wdata = '0;
   int unsigned   cycle_count = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_idle_pct = 0;

   mtkd_req_if req_ch ();
   mtkd_rsp_if rsp_ch ();

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_RESTART;
      req_ch.data_in = '0;
      rsp_ch.ready   = 1'b0;
   end

   mt19937_keyed_byte_decrypt_top i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch @%0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   class decrypt_scoreboard;
      logic [31:0] seed_reg, words[MT_N];
      logic [7:0]  key_a_reg, key_b_reg, delta_reg, key_a, key_b;
      int unsigned word_pos;
      logic [7:0]  plain_q[$];

      function new();
         seed_reg = SEED_RESET; key_a_reg = KEY_A_RESET;
         key_b_reg = KEY_B_RESET; delta_reg = DELTA_RESET;
         reseed(32'h0);
         key_a = 8'h0; key_b = 8'h0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_SEED:  seed_reg  = val;
            CSR_KEY_A: key_a_reg = val[7:0];
            CSR_KEY_B: key_b_reg = val[7:0];
            CSR_DELTA: delta_reg = val[7:0];
            default:   seed_reg  = seed_reg;
         endcase
      endfunction

      function void reseed(logic [31:0] s);
         logic [63:0] prod;
         words[0] = s;
         for (int i = 1; i < MT_N; i++) begin
            prod = 64'(32'd1812433253) * 64'(words[i-1] ^ (words[i-1] >> 30)) + 64'(i);
            words[i] = prod[31:0];
         end
         word_pos = MT_N;
      endfunction

      function logic [31:0] combine(logic [31:0] hi, logic [31:0] lo, logic [31:0] far);
         logic [31:0] y;
         y = {hi[31], lo[30:0]};
         return far ^ (y >> 1) ^ (y[0] ? 32'h9908_B0DF : 32'h0);
      endfunction

      function logic [31:0] next_tempered();
         logic [31:0] y;
         if (word_pos >= MT_N) begin
            for (int k = 0; k < MT_N; k++)
               words[k] = combine(words[k], words[(k+1) % MT_N], words[(k+MT_M) % MT_N]);
            word_pos = 0;
         end
         y = words[word_pos];
         word_pos++;
         y ^= y >> 11;
         y ^= (y << 7) & 32'h9D2C_5680;
         y ^= (y << 15) & 32'hEFC6_0000;
         y ^= y >> 18;
         return y;
      endfunction

      function void note_input(logic kind, logic [7:0] data);
         logic [31:0] t;
         if (kind == KIND_RESTART) begin
            reseed(seed_reg);
            key_a = key_a_reg; key_b = key_b_reg;
         end else begin
            t = next_tempered();
            plain_q = {plain_q, data ^ t[7:0] ^ key_a};
            key_a += key_b;
            key_b += delta_reg;
         end
      endfunction

      task check_result(logic [7:0] got);
         logic [7:0] want;
         if (plain_q.size() == 0) begin
            report_mismatch($sformatf("unexpected data_out %02h", got));
            return;
         end
         want = plain_q.pop_front();
         if (got !== want)
            report_mismatch($sformatf("data_out %02h, expected %02h", got, want));
      endtask
   endclass

   decrypt_scoreboard sb = new();

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_input(req_ch.kind, req_ch.data_in);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data_out);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_word(input logic kind, input logic [7:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.data_in <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.plain_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic write_regs(input logic [31:0] s, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] d);
      write_reg(CSR_SEED, s);
      write_reg(CSR_KEY_A, a);
      write_reg(CSR_KEY_B, b);
      write_reg(CSR_DELTA, d);
      csr_we <= 1'b0;
   endtask

   task automatic random_message(input int unsigned n);
      if ($urandom_range(9) != 0) send_word(KIND_RESTART, 8'($urandom));
      repeat (n) send_word(KIND_DATA, 8'($urandom));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // data before any restart, then default keys
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'hFF);
      send_word(KIND_RESTART, 8'hA5);
      send_word(KIND_DATA, 8'h55);
      send_word(KIND_DATA, 8'hAA);
      drain();
      write_regs(32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF);
      send_word(KIND_DATA, 8'h0F);  // writes not yet in effect
      send_word(KIND_RESTART, 8'h00);
      repeat (4) send_word(KIND_DATA, 8'($urandom));
      drain();
      write_regs(32'h0, 32'h0, 32'h0, 32'h0);
      send_word(KIND_RESTART, 8'hFF);
      repeat (4) send_word(KIND_DATA, 8'($urandom));
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 78 : 0;
         recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 31 : 0;
         for (int m = 0; m < 3; m++) begin
            drain();
            write_regs($urandom, $urandom, $urandom, $urandom);
            send_word(KIND_RESTART, 8'($urandom));
            // one message crosses a twist boundary
            random_message((m == 1 && phase == 2) ? 700 : $urandom_range(20, 60));
         end
         random_message($urandom_range(20, 60));
      end
      drain();
      if (mismatch_count == 0)
         $display("** mt19937_keyed_byte_decrypt_top: PASSED **");
      else
         $display("** mt19937_keyed_byte_decrypt_top: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("** mt19937_keyed_byte_decrypt_top: FAILED **");
         $finish;
      end
   end
endmodule
`default_nettype wire
